// ===== hdl/pc_pkg.sv =====
// shared constants, codes and controller/datapath structs for the path canonicalizer
// no dependencies
package pc_pkg;

    localparam int MAX_LEN     = 64;
    localparam int STACK_DEPTH = (MAX_LEN + 1) / 2;
    localparam int PTR_W       = $clog2(MAX_LEN + 1);
    localparam int ADDR_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEN_W       = 7;
    localparam int LEN_SAT     = 127;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic take;       // request accepted, process its byte
        logic put_slash;  // store the leading slash of a new segment
        logic close;      // close the open segment at end of path
        logic rd;         // load the output register from the store
        logic next;       // advance the read pointer
        logic clear;      // return to reset state
    } pc_cmd_t;

    typedef struct packed {
        logic need_slash; // offered byte opens a segment, slash not yet stored
        logic empty;      // nothing kept, emit a lone slash
        logic at_end;     // read pointer is on the final stored byte
    } pc_status_t;

endpackage

// ===== hdl/pc_in_if.sv =====
// input channel: one path byte per request with a last flag
// depends on nothing
interface pc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       is_last;

    modport source (output valid, output path_byte, output is_last, input ready);
    modport sink   (input valid, input path_byte, input is_last, output ready);
endinterface

// ===== hdl/pc_out_if.sv =====
// output channel: one canonical path byte per request with last and overflow flags
// depends on nothing
interface pc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;

    modport source (output valid, output out_byte, output out_last, output overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input overflow,
                    output ready);
endinterface

// ===== hdl/path_canonicalizer.sv =====
// a path byte is accepted when offered; a byte that opens a segment first waits while its leading
// slash is stored; after the last byte the final segment is closed, then each output
// byte is read through the registered read port of the byte store and offered, the next
// only once it is taken; no new path is taken while the result burst is out
// reset: asynchronous, clears all control state; store and stack contents are not cleared
module path_canonicalizer (
    input logic      clk,
    input logic      rst_n,
    pc_in_if.sink    path,
    pc_out_if.source canon
);
    import pc_pkg::*;

    pc_cmd_t    cmd;
    pc_status_t status;

    pc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (path.valid),
        .in_last   (path.is_last),
        .in_ready  (path.ready),
        .out_valid (canon.valid),
        .out_ready (canon.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (path.path_byte),
        .cmd      (cmd),
        .status   (status),
        .out_byte (canon.out_byte),
        .out_last (canon.out_last),
        .overflow (canon.overflow)
    );

endmodule

// ===== hdl/pc_ctrl.sv =====
// controller state machine: intake, final segment close and output burst
// depends on pc_pkg
module pc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pc_pkg::pc_status_t status,
    output pc_pkg::pc_cmd_t    cmd
);
    import pc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLOSE = 4'b0010,
        ST_READ  = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   final_byte;

    assign final_byte = status.empty | status.at_end;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // a byte that opens a segment waits while its slash is stored
                if (in_valid && status.need_slash)
                begin
                    cmd.put_slash = 1'b1;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.take = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_CLOSE;
                        end
                    end
                end
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (final_byte)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/pc_datapath.sv =====
// datapath: byte store, segment start stack, segment tracking and output register
// depends on pc_pkg
module pc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_byte,
    input  pc_pkg::pc_cmd_t    cmd,
    output pc_pkg::pc_status_t status,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic               overflow
);
    import pc_pkg::*;

    logic [7:0]        store_mem [MAX_LEN];
    logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];

    logic [PTR_W-1:0]  write_pos_reg, write_pos_next;
    logic [PTR_W-1:0]  seg_start_reg, seg_start_next;
    logic [LEN_W-1:0]  seg_len_reg, seg_len_next;
    logic [SCNT_W-1:0] stack_count_reg, stack_count_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              all_dots_reg, all_dots_next;
    logic              slash_seen_reg, slash_seen_next;
    logic              seg_open_reg, seg_open_next;
    logic              overflow_reg, overflow_next;
    logic [7:0]        out_byte_reg;
    logic [ADDR_W-1:0] stack_top_reg;

    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic              push_we;
    logic              pop_en;
    logic              close_en;
    logic              room;
    logic              is_slash;

    assign room     = write_pos_reg < PTR_W'(MAX_LEN);
    assign is_slash = in_byte == CH_SLASH;

    assign status.need_slash = slash_seen_reg && !is_slash && seg_len_reg == '0
                               && !seg_open_reg;
    assign status.empty      = write_pos_reg == '0;
    assign status.at_end     = (rd_ptr_reg + PTR_W'(1)) == write_pos_reg;

    assign out_byte = out_byte_reg;
    assign out_last = status.empty | status.at_end;
    assign overflow = overflow_reg;

    always_comb
    begin
        write_pos_next   = write_pos_reg;
        seg_start_next   = seg_start_reg;
        seg_len_next     = seg_len_reg;
        stack_count_next = stack_count_reg;
        rd_ptr_next      = rd_ptr_reg;
        all_dots_next    = all_dots_reg;
        slash_seen_next  = slash_seen_reg;
        seg_open_next    = seg_open_reg;
        overflow_next    = overflow_reg;
        mem_we           = 1'b0;
        mem_wdata        = in_byte;
        push_we          = 1'b0;
        pop_en           = 1'b0;
        close_en         = cmd.close | (cmd.take & slash_seen_reg & is_slash);

        if (cmd.put_slash)
        begin
            seg_start_next = write_pos_reg;
            seg_open_next  = 1'b1;
            mem_wdata      = CH_SLASH;
            if (room)
            begin
                mem_we         = 1'b1;
                write_pos_next = write_pos_reg + PTR_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.take)
        begin
            if (!slash_seen_reg)
            begin
                // bytes ahead of the first slash are ignored
                if (is_slash)
                begin
                    slash_seen_next = 1'b1;
                end
            end
            else if (!is_slash)
            begin
                if (room)
                begin
                    mem_we         = 1'b1;
                    write_pos_next = write_pos_reg + PTR_W'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                if (in_byte != CH_DOT)
                begin
                    all_dots_next = 1'b0;
                end
                if (seg_len_reg < LEN_W'(LEN_SAT))
                begin
                    seg_len_next = seg_len_reg + LEN_W'(1);
                end
                seg_open_next = 1'b0;
            end
        end

        if (close_en && seg_len_reg != '0)
        begin
            if (all_dots_reg && seg_len_reg == LEN_W'(1))
            begin
                write_pos_next = seg_start_reg;
            end
            else if (all_dots_reg && seg_len_reg == LEN_W'(2))
            begin
                // parent segment: pop back to its leading slash
                if (stack_count_reg != '0)
                begin
                    pop_en           = 1'b1;
                    stack_count_next = stack_count_reg - SCNT_W'(1);
                    write_pos_next   = PTR_W'(stack_top_reg);
                end
                else
                begin
                    write_pos_next = seg_start_reg;
                end
            end
            else if (seg_start_reg < PTR_W'(MAX_LEN))
            begin
                if (stack_count_reg < SCNT_W'(STACK_DEPTH))
                begin
                    push_we          = 1'b1;
                    stack_count_next = stack_count_reg + SCNT_W'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
            seg_len_next  = '0;
            all_dots_next = 1'b1;
            seg_open_next = 1'b0;
        end

        if (cmd.next)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end

        if (cmd.clear)
        begin
            write_pos_next   = '0;
            seg_start_next   = '0;
            seg_len_next     = '0;
            stack_count_next = '0;
            rd_ptr_next      = '0;
            all_dots_next    = 1'b1;
            slash_seen_next  = 1'b0;
            seg_open_next    = 1'b0;
            overflow_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg   <= '0;
            seg_start_reg   <= '0;
            seg_len_reg     <= '0;
            stack_count_reg <= '0;
            rd_ptr_reg      <= '0;
            all_dots_reg    <= 1'b1;
            slash_seen_reg  <= 1'b0;
            seg_open_reg    <= 1'b0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            write_pos_reg   <= write_pos_next;
            seg_start_reg   <= seg_start_next;
            seg_len_reg     <= seg_len_next;
            stack_count_reg <= stack_count_next;
            rd_ptr_reg      <= rd_ptr_next;
            all_dots_reg    <= all_dots_next;
            slash_seen_reg  <= slash_seen_next;
            seg_open_reg    <= seg_open_next;
            overflow_reg    <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[write_pos_reg[ADDR_W-1:0]] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            out_byte_reg <= status.empty ? CH_SLASH : store_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    // top entry kept in a register, refilled from the entry below it on a pop
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            stack_mem[SIDX_W'(stack_count_reg)] <= seg_start_reg[ADDR_W-1:0];
            stack_top_reg                       <= seg_start_reg[ADDR_W-1:0];
        end
        else if (pop_en)
        begin
            stack_top_reg <= stack_mem[SIDX_W'(stack_count_reg - SCNT_W'(2))];
        end
    end

endmodule

// ===== hdl/pc_checker.sv =====
// port-level checks for the path canonicalizer, attached by bind
// depends on path_canonicalizer ports
module pc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last,
    input logic       overflow
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped before it was taken");

    // intake is closed during the result burst
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // the burst ends with its last byte
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("result after the final byte of the burst");

    // the burst continues and carries one overflow value
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |-> ##2 (out_valid && overflow == $past(overflow, 2)))
        else $error("burst broken or overflow changed within it");

endmodule

bind path_canonicalizer pc_checker u_pc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (path.ready),
    .out_valid (canon.valid),
    .out_ready (canon.ready),
    .out_last  (canon.out_last),
    .overflow  (canon.overflow)
);
